FILE: hw/rtl/wjc_pkg.sv
// Shared types, widths and codes of the window jitter classifier.
package wjc_pkg;

   localparam int IFACE_W     = 3;
   localparam int RTT_W       = 17;
   localparam int SAMPLE_W    = 16;
   localparam int RING_W      = SAMPLE_W + 1;
   localparam int CNT_W       = 7;
   localparam int WINDOW_MAX  = 64;
   localparam int HEAD_W      = $clog2(WINDOW_MAX);
   localparam int NUM_IFACES  = 8;
   localparam int SUM_W       = SAMPLE_W + HEAD_W;
   localparam int SQ_W        = 2 * SAMPLE_W + HEAD_W;
   localparam int LIMIT_W     = 16;
   localparam int JQ_W        = 20;
   localparam int PROD_W      = SQ_W + CNT_W;
   localparam int ROOT_IN_W   = PROD_W + 9;
   localparam int ROOT_W      = ROOT_IN_W / 2;
   localparam int STEP_W      = $clog2(ROOT_W);
   localparam int GN_W        = LIMIT_W + CNT_W;
   localparam int GG_W        = 2 * GN_W;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_W       = 16;

   localparam logic [CNT_W-1:0]   WS_RESET       = CNT_W'(16);
   localparam logic [LIMIT_W-1:0] GOOD_RESET     = LIMIT_W'(20);
   localparam logic [LIMIT_W-1:0] DEGRADED_RESET = LIMIT_W'(50);

   localparam logic [CSR_IDX_W-1:0] CSR_WIN_LEN        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOOD_LIMIT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEGRADED_LIMIT = 2'd2;

   typedef enum logic [1:0] {
      LVL_UNKNOWN  = 2'd0,
      LVL_GOOD     = 2'd1,
      LVL_DEGRADED = 2'd2,
      LVL_POOR     = 2'd3
   } level_type;

   typedef struct packed {
      logic [HEAD_W-1:0] head;
      logic [CNT_W-1:0]  fill;
      logic [CNT_W-1:0]  valid;
      logic [SUM_W-1:0]  sum;
      logic [SQ_W-1:0]   sq;
   } stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RING,
      ST_UPDATE,
      ST_MUL1,
      ST_MUL2,
      ST_CMP,
      ST_ROOT,
      ST_DONE
   } top_state_type;

   typedef enum logic [1:0] {
      RD_IDLE,
      RD_ROOT,
      RD_DIV,
      RD_DONE
   } rd_state_type;

endpackage

FILE: hw/rtl/wjc_ring_mem.sv
// Sample ring memory: one window of samples per interface, one read and one write port.
module wjc_ring_mem #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [wjc_pkg::RING_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [wjc_pkg::RING_W-1:0] rd_data
);

   logic [wjc_pkg::RING_W-1:0] mem [DEPTH];
   logic [wjc_pkg::RING_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/wjc_stat_mem.sv
// Per-interface statistics memory with entry valid bits; an unwritten entry reads as zero.
module wjc_stat_mem #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output wjc_pkg::stat_type    rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  wjc_pkg::stat_type    wr_data
);

   wjc_pkg::stat_type mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   wjc_pkg::stat_type rd_data_ff;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

FILE: hw/rtl/wjc_root_div.sv
// Iterative square root, one result bit a cycle, then restoring divide by the sample count.
module wjc_root_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wjc_pkg::ROOT_IN_W-1:0] x_in,
   input  logic [wjc_pkg::CNT_W-1:0]     n_in,
   output logic                          done,
   output logic [wjc_pkg::JQ_W-1:0]      q_out
);

   localparam int XW = wjc_pkg::ROOT_IN_W;
   localparam int RW = wjc_pkg::ROOT_W;
   localparam int NW = wjc_pkg::CNT_W;

   wjc_pkg::rd_state_type state_ff, state_in;
   logic [XW-1:0]               x_ff, x_in_r, r_ff, r_in, b_ff, b_in;
   logic [RW-1:0]               quo_ff, quo_in;
   logic [NW-1:0]               rem_ff, rem_in, n_ff, n_in_r;
   logic [wjc_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [XW-1:0]               trial;
   logic [NW:0]                 rem2;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wjc_pkg::RD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in_r;
      r_ff    <= r_in;
      b_ff    <= b_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      n_ff    <= n_in_r;
      step_ff <= step_in;
   end

   always_comb begin
      state_in = state_ff;
      x_in_r   = x_ff;
      r_in     = r_ff;
      b_in     = b_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      n_in_r   = n_ff;
      step_in  = step_ff;
      trial    = r_ff + b_ff;
      rem2     = {rem_ff, quo_ff[RW-1]};
      done     = 1'b0;
      case (state_ff)
         wjc_pkg::RD_IDLE: begin
            if (start) begin
               x_in_r   = x_in;
               r_in     = '0;
               b_in     = XW'(1) << (XW - 2);
               n_in_r   = n_in;
               state_in = wjc_pkg::RD_ROOT;
            end
         end
         wjc_pkg::RD_ROOT: begin
            // accept the trial bit when the remainder covers it
            if (x_ff >= trial) begin
               x_in_r = x_ff - trial;
               r_in   = (r_ff >> 1) + b_ff;
            end else begin
               r_in   = r_ff >> 1;
            end
            b_in = b_ff >> 2;
            if (b_ff[0]) begin
               quo_in   = r_in[RW-1:0];
               rem_in   = '0;
               step_in  = wjc_pkg::STEP_W'(RW - 1);
               state_in = wjc_pkg::RD_DIV;
            end
         end
         wjc_pkg::RD_DIV: begin
            if (rem2 >= {1'b0, n_ff}) begin
               rem_in = NW'(rem2 - {1'b0, n_ff});
               quo_in = {quo_ff[RW-2:0], 1'b1};
            end else begin
               rem_in = rem2[NW-1:0];
               quo_in = {quo_ff[RW-2:0], 1'b0};
            end
            step_in = step_ff - wjc_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               state_in = wjc_pkg::RD_DONE;
            end
         end
         wjc_pkg::RD_DONE: begin
            done     = 1'b1;
            state_in = wjc_pkg::RD_IDLE;
         end
         default: begin
            state_in = wjc_pkg::RD_IDLE;
         end
      endcase
   end

   assign q_out = quo_ff[wjc_pkg::JQ_W-1:0];

endmodule

FILE: hw/rtl/window_jitter_classifier.sv
// Top level of the per-interface sliding-window jitter classifier.
//
// Usage: each request beat carries one round-trip sample (req_rtt_ms, negative
// means timeout) for interface req_iface. The block pushes it into that
// interface's ring of the last samples (length set by csr register 0), updates
// the running sum, sum of squares and valid count, and returns one response
// beat with the standard deviation in 1/16 ms (rsp_jitter_q4), a quality level
// and the valid and fill counts of the window.
// The response beat follows the statistics and ring reads, the update, the
// products and compares, the bit-serial square root, the serial divide by the
// valid count and the handback of the quotient. With fewer than two valid
// samples the root is skipped. One request is in flight at a time and
// req_stall drops as the response is loaded, so a new request is taken only
// once the last one's response is loaded.
// A response waits in the output register while rsp_stall is high; the next
// request is taken meanwhile and holds before output until the register frees.
// Reset (synchronous) empties every ring and sets window length 16, limits 20
// and 50. A csr write of register 0 also empties every ring at once.
module window_jitter_classifier #(
   parameter int NUM_IFACES = wjc_pkg::NUM_IFACES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [wjc_pkg::IFACE_W-1:0]       req_iface,
   input  logic signed [wjc_pkg::RTT_W-1:0]  req_rtt_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [wjc_pkg::IFACE_W-1:0]       rsp_iface_out,
   output logic [wjc_pkg::JQ_W-1:0]          rsp_jitter_q4,
   output logic [1:0]                        rsp_level,
   output logic [wjc_pkg::CNT_W-1:0]         rsp_valid_count,
   output logic [wjc_pkg::CNT_W-1:0]         rsp_fill_count,
   input  logic                              csr_write,
   input  logic [wjc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wjc_pkg::CSR_W-1:0]         csr_wdata
);

   // Only interface indexes below eight can ever be addressed.
   localparam int STAT_DEPTH = (NUM_IFACES < 8) ? NUM_IFACES : 8;
   localparam int IDX_W      = (STAT_DEPTH > 1) ? $clog2(STAT_DEPTH) : 1;
   localparam int RING_DEPTH = STAT_DEPTH * wjc_pkg::WINDOW_MAX;
   localparam int RING_AW    = IDX_W + wjc_pkg::HEAD_W;
   localparam int CW         = wjc_pkg::CNT_W;
   localparam int PW         = wjc_pkg::PROD_W;

   // Configuration registers
   logic [CW-1:0]               ws_ff;
   logic [wjc_pkg::LIMIT_W-1:0] good_ff, degr_ff;
   logic                        ws_write;
   logic [CW-1:0]               ws_clamped;

   // Control and datapath registers
   wjc_pkg::top_state_type      state_ff, state_in;
   logic [wjc_pkg::IFACE_W-1:0] idx_ff, idx_in, idx_red;
   logic                        ok_ff, ok_in;
   logic [wjc_pkg::SAMPLE_W-1:0] v_ff, v_in;
   logic [wjc_pkg::HEAD_W-1:0]  pos_ff, pos_in;
   logic                        full_ff, full_in;
   wjc_pkg::stat_type           upd_ff, upd_in;
   logic [PW-1:0]               a_ff, a_in, b_ff, b_in, d_ff, d_in;
   logic [wjc_pkg::GN_W-1:0]    gn_ff, gn_in, dn_ff, dn_in;
   logic [wjc_pkg::GG_W-1:0]    gg_ff, gg_in, dd_ff, dd_in;
   wjc_pkg::level_type          lvl_ff, lvl_in;
   logic [wjc_pkg::JQ_W-1:0]    q_ff, q_in;

   // Response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [wjc_pkg::IFACE_W-1:0] rsp_iface_ff, rsp_iface_in;
   logic [wjc_pkg::JQ_W-1:0]    rsp_jq_ff, rsp_jq_in;
   wjc_pkg::level_type          rsp_lvl_ff, rsp_lvl_in;
   logic [CW-1:0]               rsp_vc_ff, rsp_vc_in, rsp_fc_ff, rsp_fc_in;

   // Memory and unit hookups
   logic                        accept;
   wjc_pkg::stat_type           stat_rd;
   logic                        stat_we;
   logic [wjc_pkg::RING_W-1:0]  ring_rd;
   logic                        ring_re, ring_we;
   logic [RING_AW-1:0]          ring_raddr;
   logic                        root_start, root_done;
   logic [wjc_pkg::JQ_W-1:0]    root_q;

   // Working values of the update step
   logic                        old_ok;
   logic [wjc_pkg::SAMPLE_W-1:0] old_v, add_v;
   logic [2*wjc_pkg::SAMPLE_W-1:0] old_sq, add_sq;
   logic [wjc_pkg::HEAD_W:0]    pos_next;
   logic [wjc_pkg::HEAD_W-1:0]  pos_now;
   logic [wjc_pkg::IFACE_W-1:0] red;

   assign accept = req_valid && !req_stall;

   // ---- configuration ----
   assign ws_write = csr_write && (csr_index == wjc_pkg::CSR_WIN_LEN);

   always_comb begin
      ws_clamped = csr_wdata[CW-1:0];
      if (ws_clamped == '0) begin
         ws_clamped = CW'(1);
      end else if (ws_clamped > CW'(wjc_pkg::WINDOW_MAX)) begin
         ws_clamped = CW'(wjc_pkg::WINDOW_MAX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff   <= wjc_pkg::WS_RESET;
         good_ff <= wjc_pkg::GOOD_RESET;
         degr_ff <= wjc_pkg::DEGRADED_RESET;
      end else if (csr_write) begin
         case (csr_index)
            wjc_pkg::CSR_WIN_LEN:        ws_ff   <= ws_clamped;
            wjc_pkg::CSR_GOOD_LIMIT:     good_ff <= csr_wdata;
            wjc_pkg::CSR_DEGRADED_LIMIT: degr_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Reduce the interface index modulo the interface count.
   always_comb begin
      red = req_iface;
      for (int i = 0; i < 8; i++) begin
         if ({1'b0, red} >= 4'(STAT_DEPTH < 8 ? NUM_IFACES : 8)) begin
            red = wjc_pkg::IFACE_W'({1'b0, red} - 4'(NUM_IFACES));
         end
      end
      idx_red = red;
   end

   // ---- storage ----
   wjc_stat_mem #(
      .DEPTH  (STAT_DEPTH),
      .ADDR_W (IDX_W)
   ) u_stat_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (ws_write),
      .rd_en   (accept),
      .rd_addr (idx_red[IDX_W-1:0]),
      .rd_data (stat_rd),
      .wr_en   (stat_we),
      .wr_addr (idx_ff[IDX_W-1:0]),
      .wr_data (upd_in)
   );

   wjc_ring_mem #(
      .DEPTH  (RING_DEPTH),
      .ADDR_W (RING_AW)
   ) u_ring_mem (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr ({idx_ff[IDX_W-1:0], pos_ff}),
      .wr_data ({ok_ff, v_ff}),
      .rd_en   (ring_re),
      .rd_addr (ring_raddr),
      .rd_data (ring_rd)
   );

   wjc_root_div u_root_div (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .x_in  ({1'b0, d_ff, 8'b0}),
      .n_in  (upd_ff.valid),
      .done  (root_done),
      .q_out (root_q)
   );

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wjc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      ok_ff        <= ok_in;
      v_ff         <= v_in;
      pos_ff       <= pos_in;
      full_ff      <= full_in;
      upd_ff       <= upd_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      d_ff         <= d_in;
      gn_ff        <= gn_in;
      dn_ff        <= dn_in;
      gg_ff        <= gg_in;
      dd_ff        <= dd_in;
      lvl_ff       <= lvl_in;
      q_ff         <= q_in;
      rsp_iface_ff <= rsp_iface_in;
      rsp_jq_ff    <= rsp_jq_in;
      rsp_lvl_ff   <= rsp_lvl_in;
      rsp_vc_ff    <= rsp_vc_in;
      rsp_fc_ff    <= rsp_fc_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      ok_in        = ok_ff;
      v_in         = v_ff;
      pos_in       = pos_ff;
      full_in      = full_ff;
      upd_in       = upd_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      d_in         = d_ff;
      gn_in        = gn_ff;
      dn_in        = dn_ff;
      gg_in        = gg_ff;
      dd_in        = dd_ff;
      lvl_in       = lvl_ff;
      q_in         = q_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_iface_in = rsp_iface_ff;
      rsp_jq_in    = rsp_jq_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      rsp_vc_in    = rsp_vc_ff;
      rsp_fc_in    = rsp_fc_ff;
      req_stall    = 1'b1;
      stat_we      = 1'b0;
      ring_re      = 1'b0;
      ring_we      = 1'b0;
      root_start   = 1'b0;
      pos_now      = (CW'(stat_rd.head) >= ws_ff) ? '0 : stat_rd.head;
      ring_raddr   = {idx_ff[IDX_W-1:0], pos_now};
      old_ok       = full_ff && ring_rd[wjc_pkg::SAMPLE_W];
      old_v        = old_ok ? ring_rd[wjc_pkg::SAMPLE_W-1:0] : '0;
      add_v        = ok_ff ? v_ff : '0;
      old_sq       = old_v * old_v;
      add_sq       = add_v * add_v;
      pos_next     = {1'b0, pos_ff} + (wjc_pkg::HEAD_W + 1)'(1);

      case (state_ff)
         wjc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               // Latch the beat; a negative sample is a timeout and counts as zero.
               idx_in   = idx_red;
               ok_in    = !req_rtt_ms[wjc_pkg::RTT_W-1];
               v_in     = ok_in ? req_rtt_ms[wjc_pkg::SAMPLE_W-1:0] : '0;
               state_in = wjc_pkg::ST_RING;
            end
         end
         wjc_pkg::ST_RING: begin
            // Stats are back: find the slot and fetch the sample it will evict.
            ring_re  = 1'b1;
            pos_in   = pos_now;
            full_in  = stat_rd.fill >= ws_ff;
            upd_in   = stat_rd;
            state_in = wjc_pkg::ST_UPDATE;
         end
         wjc_pkg::ST_UPDATE: begin
            // Drop the evicted sample, add the new one, write both stores back.
            upd_in.sum   = upd_ff.sum - wjc_pkg::SUM_W'(old_v) + wjc_pkg::SUM_W'(add_v);
            upd_in.sq    = upd_ff.sq - wjc_pkg::SQ_W'(old_sq) + wjc_pkg::SQ_W'(add_sq);
            upd_in.valid = upd_ff.valid - CW'(old_ok) + CW'(ok_ff);
            upd_in.fill  = full_ff ? upd_ff.fill : upd_ff.fill + CW'(1);
            upd_in.head  = (CW'(pos_next) >= ws_ff) ? '0 : pos_next[wjc_pkg::HEAD_W-1:0];
            stat_we      = 1'b1;
            ring_we      = 1'b1;
            state_in     = wjc_pkg::ST_MUL1;
         end
         wjc_pkg::ST_MUL1: begin
            a_in     = PW'(upd_ff.valid) * PW'(upd_ff.sq);
            b_in     = PW'(upd_ff.sum) * PW'(upd_ff.sum);
            gn_in    = wjc_pkg::GN_W'(good_ff) * wjc_pkg::GN_W'(upd_ff.valid);
            dn_in    = wjc_pkg::GN_W'(degr_ff) * wjc_pkg::GN_W'(upd_ff.valid);
            state_in = wjc_pkg::ST_MUL2;
         end
         wjc_pkg::ST_MUL2: begin
            d_in     = (a_ff > b_ff) ? a_ff - b_ff : '0;
            gg_in    = wjc_pkg::GG_W'(gn_ff) * wjc_pkg::GG_W'(gn_ff);
            dd_in    = wjc_pkg::GG_W'(dn_ff) * wjc_pkg::GG_W'(dn_ff);
            state_in = wjc_pkg::ST_CMP;
         end
         wjc_pkg::ST_CMP: begin
            // Compare N^2*var against limit^2*N^2 exactly; good is tested first.
            if (upd_ff.valid < CW'(2)) begin
               lvl_in   = wjc_pkg::LVL_UNKNOWN;
               q_in     = '0;
               state_in = wjc_pkg::ST_DONE;
            end else begin
               if (wjc_pkg::GG_W'(d_ff) <= gg_ff) begin
                  lvl_in = wjc_pkg::LVL_GOOD;
               end else if (wjc_pkg::GG_W'(d_ff) <= dd_ff) begin
                  lvl_in = wjc_pkg::LVL_DEGRADED;
               end else begin
                  lvl_in = wjc_pkg::LVL_POOR;
               end
               root_start = 1'b1;
               state_in   = wjc_pkg::ST_ROOT;
            end
         end
         wjc_pkg::ST_ROOT: begin
            if (root_done) begin
               q_in     = root_q;
               state_in = wjc_pkg::ST_DONE;
            end
         end
         wjc_pkg::ST_DONE: begin
            // Hold until the response register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_iface_in = idx_ff;
               rsp_jq_in    = q_ff;
               rsp_lvl_in   = lvl_ff;
               rsp_vc_in    = upd_ff.valid;
               rsp_fc_in    = upd_ff.fill;
               state_in     = wjc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wjc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_iface_out   = rsp_iface_ff;
   assign rsp_jitter_q4   = rsp_jq_ff;
   assign rsp_level       = rsp_lvl_ff;
   assign rsp_valid_count = rsp_vc_ff;
   assign rsp_fill_count  = rsp_fc_ff;

endmodule

FILE: hw/rtl/wjc_checker.sv
// Port-level checks of the jitter classifier, bound to the top level.
module wjc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [wjc_pkg::IFACE_W-1:0]       rsp_iface_out,
   input logic [wjc_pkg::JQ_W-1:0]          rsp_jitter_q4,
   input logic [1:0]                        rsp_level,
   input logic [wjc_pkg::CNT_W-1:0]         rsp_valid_count,
   input logic [wjc_pkg::CNT_W-1:0]         rsp_fill_count
);

   // A stalled response beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_iface_out)
                                 && $stable(rsp_jitter_q4) && $stable(rsp_level)
                                 && $stable(rsp_valid_count) && $stable(rsp_fill_count))
      else $error("stalled response beat changed");

   // One request in flight: the port closes right after a beat is taken.
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   // Unknown level carries zero jitter.
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_level == wjc_pkg::LVL_UNKNOWN) |-> rsp_jitter_q4 == '0)
      else $error("unknown level with nonzero jitter");

   // Counts stay within the window.
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_valid_count <= rsp_fill_count) && (rsp_fill_count != '0)
                    && (rsp_fill_count <= wjc_pkg::CNT_W'(wjc_pkg::WINDOW_MAX)))
      else $error("window counts out of range");

   // Fewer than two valid samples always reads as unknown.
   a_level_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_valid_count < wjc_pkg::CNT_W'(2))
      |-> rsp_level == wjc_pkg::LVL_UNKNOWN)
      else $error("level rated with too few samples");

endmodule

bind window_jitter_classifier wjc_checker u_wjc_checker (.*);

FILE: test/testbench.sv
// Self-checking testbench of the window jitter classifier.
module testbench;

   localparam logic [wjc_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;   // no register at this index
   localparam int DRAIN_CYCLES = 100;                   // above the response time of one beat
   localparam int EXP_DEPTH    = 16;                    // expected beats in flight, at most 2
   localparam int PHASE_ITEMS  = 173;                   // beats per random phase

   typedef struct packed {
      logic [wjc_pkg::IFACE_W-1:0] iface;
      logic [wjc_pkg::JQ_W-1:0]    jitter;
      wjc_pkg::level_type          level;
      logic [wjc_pkg::CNT_W-1:0]   valid_cnt;
      logic [wjc_pkg::CNT_W-1:0]   fill_cnt;
   } jitter_beat_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [wjc_pkg::IFACE_W-1:0]         req_iface = '0;
   logic signed [wjc_pkg::RTT_W-1:0]    req_rtt_ms = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [wjc_pkg::IFACE_W-1:0]         rsp_iface_out;
   logic [wjc_pkg::JQ_W-1:0]            rsp_jitter_q4;
   logic [1:0]                          rsp_level;
   logic [wjc_pkg::CNT_W-1:0]           rsp_valid_count;
   logic [wjc_pkg::CNT_W-1:0]           rsp_fill_count;
   logic                                csr_write = 1'b0;
   logic [wjc_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [wjc_pkg::CSR_W-1:0]           csr_wdata = '0;

   window_jitter_classifier dut (.*);

   // Clock: period 8.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Jitter predictor: its own copy of rings, counts, sums and registers.
   // ---------------------------------------------------------------------
   logic [wjc_pkg::SAMPLE_W-1:0] ring_val [wjc_pkg::NUM_IFACES][wjc_pkg::WINDOW_MAX];
   bit                  ring_ok  [wjc_pkg::NUM_IFACES][wjc_pkg::WINDOW_MAX];
   int                  ring_pos [wjc_pkg::NUM_IFACES];
   int                  ring_cnt [wjc_pkg::NUM_IFACES];
   int                  ok_cnt   [wjc_pkg::NUM_IFACES];
   longint unsigned     rtt_sum  [wjc_pkg::NUM_IFACES];
   longint unsigned     rtt_sq   [wjc_pkg::NUM_IFACES];
   int                  win_len  = 16;
   longint unsigned     good_ms  = 20;
   longint unsigned     degr_ms  = 50;

   // Expected beats in order: written at the accepting edge, read at the response.
   jitter_beat_type exp_fifo [EXP_DEPTH];
   int           exp_wr = 0;
   int           exp_rd = 0;
   int           error_count = 0;
   int           hold_cycles = 0;    // long receiver hold-off, counted down below
   int           stall_pct   = 0;    // random stall rate, 0 turns stalling off
   bit           stall_pattern = 0;  // fixed on/off pattern instead of random

   // Empty every ring; a window length write does the same.
   function automatic void clear_windows();
      for (int i = 0; i < wjc_pkg::NUM_IFACES; i++) begin
         ring_pos[i] = 0;
         ring_cnt[i] = 0;
         ok_cnt[i]   = 0;
         rtt_sum[i]  = 0;
         rtt_sq[i]   = 0;
         for (int j = 0; j < wjc_pkg::WINDOW_MAX; j++) ring_ok[i][j] = 0;
      end
   endfunction

   // Integer square root, greedy bit by bit from the top.
   function automatic longint unsigned floor_root(longint unsigned x);
      longint unsigned r, t;
      r = 0;
      for (int k = 31; k >= 0; k--) begin
         t = r | (longint'(1) << k);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   function automatic jitter_beat_type predict_jitter(logic [wjc_pkg::IFACE_W-1:0] ifc,
                                                      logic [wjc_pkg::RTT_W-1:0] raw);
      bit              ok;
      longint unsigned v, o, n, a, b, d;
      int              pos;
      jitter_beat_type r;
      ok  = !raw[wjc_pkg::RTT_W-1];
      v   = ok ? longint'(raw[wjc_pkg::SAMPLE_W-1:0]) : 0;
      pos = ring_pos[ifc];
      if (pos >= win_len) pos = 0;
      // Full ring: drop the oldest sample, which sits at the head.
      if (ring_cnt[ifc] >= win_len) begin
         if (ring_ok[ifc][pos]) begin
            o = ring_val[ifc][pos];
            rtt_sum[ifc] -= o;
            rtt_sq[ifc]  -= o * o;
            ok_cnt[ifc]  -= 1;
         end
      end else begin
         ring_cnt[ifc] += 1;
      end
      ring_val[ifc][pos] = v[wjc_pkg::SAMPLE_W-1:0];
      ring_ok[ifc][pos]  = ok;
      if (ok) begin
         rtt_sum[ifc] += v;
         rtt_sq[ifc]  += v * v;
         ok_cnt[ifc]  += 1;
      end
      ring_pos[ifc] = (pos + 1 >= win_len) ? 0 : pos + 1;

      n = ok_cnt[ifc];
      r.iface  = ifc;
      r.jitter = '0;
      r.level  = wjc_pkg::LVL_UNKNOWN;
      if (n >= 2) begin
         a = n * rtt_sq[ifc];
         b = rtt_sum[ifc] * rtt_sum[ifc];
         d = (a > b) ? a - b : 0;
         r.jitter = wjc_pkg::JQ_W'(floor_root(d << 8) / n);
         // Good is tested first, so with swapped limits nothing rates degraded and all above good rates poor.
         if (d <= good_ms * good_ms * n * n)      r.level = wjc_pkg::LVL_GOOD;
         else if (d <= degr_ms * degr_ms * n * n) r.level = wjc_pkg::LVL_DEGRADED;
         else                                     r.level = wjc_pkg::LVL_POOR;
      end
      r.valid_cnt = wjc_pkg::CNT_W'(n);
      r.fill_cnt  = wjc_pkg::CNT_W'(ring_cnt[ifc]);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driving tasks. Inputs change on the falling edge only.
   // ---------------------------------------------------------------------

   // Offer one beat and hold it until the block takes it; valid stays high.
   task automatic send_sample(logic [wjc_pkg::IFACE_W-1:0] ifc,
                              logic [wjc_pkg::RTT_W-1:0] rtt);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_iface  <= ifc;
      req_rtt_ms <= rtt;
      do @(posedge clock); while (req_stall);
      exp_fifo[exp_wr % EXP_DEPTH] = predict_jitter(ifc, rtt);
      exp_wr++;
   endtask

   // Drop valid and idle for a number of extra cycles.
   task automatic idle_sender(int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Wait until every expected beat has come, then for the block to go quiet.
   task automatic drain();
      idle_sender(0);
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register; call only while the block is idle.
   task automatic write_reg(logic [wjc_pkg::CSR_IDX_W-1:0] idx,
                            logic [wjc_pkg::CSR_W-1:0] val);
      int w;
      drain();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         wjc_pkg::CSR_WIN_LEN: begin
            w = int'(val[wjc_pkg::CNT_W-1:0]);
            if (w < 1) w = 1;
            if (w > wjc_pkg::WINDOW_MAX) w = wjc_pkg::WINDOW_MAX;
            win_len = w;
            clear_windows();
         end
         wjc_pkg::CSR_GOOD_LIMIT:     good_ms = val;
         wjc_pkg::CSR_DEGRADED_LIMIT: degr_ms = val;
         default: ;
      endcase
   endtask

   // Random sample around a base: mostly well-formed, with timeouts and noise.
   function automatic logic [wjc_pkg::RTT_W-1:0] pick_rtt(int base, int spread);
      int roll, v;
      roll = $urandom_range(0, 99);
      if (roll < 5)  return '1;
      if (roll < 8)  return {1'b1, 16'($urandom)};
      if (roll < 12) return wjc_pkg::RTT_W'($urandom);
      v = base + $urandom_range(0, spread);
      if (v > 65535) v = 65535;
      return wjc_pkg::RTT_W'(v);
   endfunction

   // ---------------------------------------------------------------------
   // Receiver stall: random, a fixed pattern, or a long counted hold-off.
   // ---------------------------------------------------------------------
   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase <= (stall_phase + 1) % 11;
      if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (stall_pct == 0) begin
         rsp_stall <= 1'b0;
      end else if (stall_pattern) begin
         rsp_stall <= (stall_phase < 4);
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Response checker: compare each accepted beat with the oldest expectation.
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      jitter_beat_type exp_beat;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (exp_wr == exp_rd) begin
            report_mismatch("response beat with nothing expected");
         end else begin
            exp_beat = exp_fifo[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_iface_out !== exp_beat.iface)
               report_mismatch($sformatf("iface_out %0d, want %0d",
                                         rsp_iface_out, exp_beat.iface));
            if (rsp_jitter_q4 !== exp_beat.jitter)
               report_mismatch($sformatf("iface %0d jitter_q4 %0d, want %0d",
                                         exp_beat.iface, rsp_jitter_q4, exp_beat.jitter));
            if (rsp_level !== exp_beat.level)
               report_mismatch($sformatf("iface %0d level %0d, want %0d",
                                         exp_beat.iface, rsp_level, exp_beat.level));
            if (rsp_valid_count !== exp_beat.valid_cnt)
               report_mismatch($sformatf("iface %0d valid_count %0d, want %0d",
                                         exp_beat.iface, rsp_valid_count, exp_beat.valid_cnt));
            if (rsp_fill_count !== exp_beat.fill_cnt)
               report_mismatch($sformatf("iface %0d fill_count %0d, want %0d",
                                         exp_beat.iface, rsp_fill_count, exp_beat.fill_cnt));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes, timeouts of either kind, and each level at reset limits.
   task automatic test_extremes();
      send_sample(3'd0, 17'd0);
      send_sample(3'd0, 17'd65535);           // widest spread, poor
      send_sample(3'd0, '1);                  // timeout as -1
      send_sample(3'd0, 17'h10000);           // most negative timeout
      send_sample(3'd7, 17'd42);              // one valid sample: unknown
      send_sample(3'd7, 17'd42);              // no spread: good at zero
      send_sample(3'd1, 17'd80);
      send_sample(3'd1, 17'd120);             // sd exactly at the good limit
      send_sample(3'd2, 17'd100);
      send_sample(3'd2, 17'd160);             // degraded
      send_sample(3'd3, 17'd0);
      send_sample(3'd3, 17'd200);             // poor
      send_sample(3'd4, 17'd10);
      send_sample(3'd4, 17'd110);             // sd exactly at the degraded limit
      send_sample(3'd5, 17'h0AAAA);
      send_sample(3'd5, 17'h05555);
      drain();
   endtask

   // Window lengths at and beyond their bounds; each write empties the rings.
   task automatic test_window_sizes();
      int sizes[5] = '{0, 1, 127, 100, 3};
      foreach (sizes[i]) begin
         write_reg(wjc_pkg::CSR_WIN_LEN, wjc_pkg::CSR_W'(sizes[i]));
         for (int k = 0; k < 5; k++) send_sample(3'd6, pick_rtt(500, 300));
         drain();
      end
      // Same value again still clears.
      write_reg(wjc_pkg::CSR_WIN_LEN, wjc_pkg::CSR_W'(3));
      send_sample(3'd6, 17'd5);
      send_sample(3'd6, 17'd9);
      drain();
   endtask

   // Limits at their extremes, in the wrong order, and the unused index.
   task automatic test_limits();
      write_reg(wjc_pkg::CSR_WIN_LEN, wjc_pkg::CSR_W'(8));
      write_reg(wjc_pkg::CSR_GOOD_LIMIT, 16'd0);
      write_reg(wjc_pkg::CSR_DEGRADED_LIMIT, 16'd65535);
      for (int k = 0; k < 6; k++) send_sample(3'(k % 2), pick_rtt(1000, 80));
      write_reg(wjc_pkg::CSR_GOOD_LIMIT, 16'd40);
      write_reg(wjc_pkg::CSR_DEGRADED_LIMIT, 16'd10);  // swapped order
      for (int k = 0; k < 6; k++) send_sample(3'(k % 2), pick_rtt(1000, 150));
      write_reg(CSR_SPARE, 16'hFFFF);         // must change nothing
      write_reg(wjc_pkg::CSR_GOOD_LIMIT, 16'd65535);
      for (int k = 0; k < 4; k++) send_sample(3'd2, pick_rtt(0, 65535));
      drain();
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering.
   task automatic test_backpressure();
      stall_pct = 0;
      @(posedge clock);
      hold_cycles = 600;
      for (int k = 0; k < 8; k++) send_sample(3'(k), pick_rtt(300, 60));
      drain();
   endtask

   // Random phases: bursts of mostly well-formed traffic under several settings.
   task automatic test_random();
      int base[wjc_pkg::NUM_IFACES];
      int spread, burst, gap;
      int sent = 0;
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(wjc_pkg::CSR_WIN_LEN,
                   wjc_pkg::CSR_W'(phase == 0 ? 64 : $urandom_range(1, 70)));
         write_reg(wjc_pkg::CSR_GOOD_LIMIT, wjc_pkg::CSR_W'($urandom_range(0, 60)));
         write_reg(wjc_pkg::CSR_DEGRADED_LIMIT, wjc_pkg::CSR_W'($urandom_range(0, 200)));
         spread        = (phase == 7) ? 65535 : $urandom_range(0, 300);
         stall_pct     = (phase % 3 == 0) ? 0 : $urandom_range(10, 70);
         stall_pattern = (phase == 4);
         foreach (base[i]) base[i] = $urandom_range(0, 2000);
         for (int k = 0; k < PHASE_ITEMS; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && k < PHASE_ITEMS; b++, k++)
               send_sample(3'($urandom),
                           pick_rtt(base[sent++ % wjc_pkg::NUM_IFACES], spread));
            gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 90) : 0;
            if (gap > 0) idle_sender(gap);
         end
         drain();
      end
      stall_pct = 0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      clear_windows();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_window_sizes();
      test_limits();
      test_backpressure();
      test_random();
      drain();
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   // Hard stop far beyond the slowest correct run.
   initial begin
      #(8 * 1500000);
      $display("testbench: errors");
      $finish;
   end

endmodule
